// ===== design/qtle_pkg.sv =====
// ============================================================================
// qtle_pkg: shared definitions for the Q table learning engine
// Table geometry, fixed-point formats, stream widths and register indexes.
// ============================================================================
`default_nettype none

package qtle_pkg;

    // Table geometry and value format.
    localparam int STATE_COUNT  = 16;
    localparam int ACTION_COUNT = 4;
    localparam int Q_WIDTH      = 24;
    localparam int FRAC_BITS    = 16;

    localparam int STATE_W = $clog2(STATE_COUNT);
    localparam int ACT_W   = $clog2(ACTION_COUNT);
    localparam int DEPTH   = STATE_COUNT * ACTION_COUNT;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(ACTION_COUNT + 1);

    // Coefficients are unsigned with 16 fraction bits, one is 2^16.
    localparam int COEF_W    = 17;
    localparam int COEF_FRAC = 16;
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC;

    // Reward and exploration fields.
    localparam int REWARD_W    = 24;
    localparam int REWARD_FRAC = 16;
    localparam int EPS_W       = 17;
    localparam int DRAW_W      = 16;

    // Input stream data: cur_state, act, reward, next_state_idx, epsilon,
    // rand_draw, rand_action, from the lowest bit up.
    localparam int S_FIELDS_W = STATE_W + ACT_W + REWARD_W + STATE_W + EPS_W
                              + DRAW_W + ACT_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    // Output stream data: chosen_action, q_value, from the lowest bit up.
    localparam int M_FIELDS_W = ACT_W + Q_WIDTH;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT   = CFG_IDX_W'(1);
    localparam logic [COEF_W-1:0] LEARN_RATE_RST = COEF_W'(6554);
    localparam logic [COEF_W-1:0] DISCOUNT_RST   = COEF_W'(64881);

    // Request kinds.
    localparam logic KIND_SELECT = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    // Sequencer states.
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SCAN  = 9'b000000010,
        ST_SEL   = 9'b000000100,
        ST_RDCUR = 9'b000001000,
        ST_MUL1  = 9'b000010000,
        ST_ADD1  = 9'b000100000,
        ST_MUL2  = 9'b001000000,
        ST_ADD2  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

endpackage

`default_nettype wire

// ===== design/qtle_ram.sv =====
// ============================================================================
// qtle_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ============================================================================
`default_nettype none

module qtle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      aclk,
    input  wire                      wr_en,
    input  wire [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire [WIDTH-1:0]          wr_data,
    input  wire                      rd_en,
    input  wire [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/q_table_learning_engine.sv =====
// A select result is set by the row scan through the single read port, an update's by
// the scan (skipped on a terminal transition) and the two registered multiplies;
// a stalled output adds its stall.
// A new request is taken only once the sequencer is back in idle, one at a time;
// a finished result may wait in the output register while the next request runs.
// Reset: synchronous, active low; valid bits zero the table, coefficients load 6554, 64881.
// ============================================================================
// q_table_learning_engine: tabular Q-learning with epsilon-greedy selection
// Holds the Q table in a RAM and serves action selection and update requests.
// ============================================================================
`default_nettype none

module q_table_learning_engine
    import qtle_pkg::*;
(
    input  wire                     aclk,
    input  wire                     aresetn,
    // Input request stream.
    input  wire                     s_tvalid,
    output logic                    s_tready,
    // Fields from bit 0: cur_state, act, reward, next_state_idx, epsilon,
    // rand_draw, rand_action, zero padding.
    input  wire [S_TDATA_W-1:0]     s_tdata,
    // Fields: kind.
    input  wire                     s_tuser,
    // Fields: is_terminal.
    input  wire                     s_tlast,
    // Result stream.
    output logic                    m_tvalid,
    input  wire                     m_tready,
    // Fields from bit 0: chosen_action, q_value, zero padding.
    output logic [M_TDATA_W-1:0]    m_tdata,
    // Configuration writes.
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire [CFG_IDX_W-1:0]     cfg_index,
    input  wire [CFG_DATA_W-1:0]    cfg_data
);

    // Field offsets within s_tdata.
    localparam int OFF_ACT   = STATE_W;
    localparam int OFF_REW   = OFF_ACT + ACT_W;
    localparam int OFF_NS    = OFF_REW + REWARD_W;
    localparam int OFF_EPS   = OFF_NS + STATE_W;
    localparam int OFF_DRAW  = OFF_EPS + EPS_W;
    localparam int OFF_RA    = OFF_DRAW + DRAW_W;

    // Arithmetic widths.
    localparam int LSH       = (FRAC_BITS >= REWARD_FRAC) ? FRAC_BITS - REWARD_FRAC : 0;
    localparam int RSH       = (REWARD_FRAC > FRAC_BITS) ? REWARD_FRAC - FRAC_BITS : 0;
    localparam int G_W       = Q_WIDTH + COEF_W + 1;
    localparam int D_W       = Q_WIDTH + LSH + 3;
    localparam int A_W       = D_W + COEF_W + 1;
    localparam int S_W       = A_W - COEF_FRAC + 1;
    localparam logic signed [S_W-1:0] Q_MAX =
        {{(S_W - Q_WIDTH + 1){1'b0}}, {(Q_WIDTH - 1){1'b1}}};
    localparam logic signed [S_W-1:0] Q_MIN = ~Q_MAX;

    // Registers.
    state_t                     st_reg, st_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       rd_vld_reg, rd_vld_next;
    logic [ACT_W-1:0]           rd_idx_reg, rd_idx_next;
    logic                       rd_hit_reg, rd_hit_next;
    logic [DEPTH-1:0]           valid_reg, valid_next;
    logic [COEF_W-1:0]          learn_reg, learn_next;
    logic [COEF_W-1:0]          disc_reg, disc_next;

    logic                       kind_reg, kind_next;
    logic [STATE_W-1:0]         cs_reg, cs_next;
    logic [STATE_W-1:0]         row_reg, row_next;
    logic [ACT_W-1:0]           act_reg, act_next;
    logic signed [REWARD_W-1:0] rew_reg, rew_next;
    logic                       explore_reg, explore_next;
    logic [ACT_W-1:0]           ra_reg, ra_next;

    logic signed [Q_WIDTH-1:0]  best_val_reg, best_val_next;
    logic [ACT_W-1:0]           best_idx_reg, best_idx_next;
    logic signed [Q_WIDTH-1:0]  ra_val_reg, ra_val_next;
    logic signed [Q_WIDTH-1:0]  cur_reg, cur_next;
    logic signed [G_W-1:0]      prod_g_reg, prod_g_next;
    logic signed [D_W-1:0]      diff_reg, diff_next;
    logic signed [A_W-1:0]      prod_a_reg, prod_a_next;
    logic [ACT_W-1:0]           res_act_reg, res_act_next;
    logic signed [Q_WIDTH-1:0]  res_q_reg, res_q_next;

    logic                       m_vld_reg, m_vld_next;
    logic [M_TDATA_W-1:0]       m_data_reg, m_data_next;

    // RAM interface.
    logic                       ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0]          ram_wr_addr, ram_rd_addr;
    logic [Q_WIDTH-1:0]         ram_wr_data, ram_rd_data;

    // Combinational helpers.
    logic                       in_acc;
    logic signed [Q_WIDTH-1:0]  rd_q;
    logic [COEF_W-1:0]          alpha_c, gamma_c;
    logic signed [D_W-1:0]      r_al;
    logic signed [S_W-1:0]      sum_q;

    qtle_ram #(
        .WIDTH (Q_WIDTH),
        .DEPTH (DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_tready  = (st_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_vld_reg;
    assign m_tdata   = m_data_reg;

    // An entry never written since reset reads as zero.
    assign rd_q = rd_hit_reg ? $signed(ram_rd_data) : '0;

    // Coefficients above one act as one.
    assign alpha_c = (learn_reg > COEF_ONE) ? COEF_ONE : learn_reg;
    assign gamma_c = (disc_reg > COEF_ONE) ? COEF_ONE : disc_reg;

    // Reward aligned to the table's fraction bits.
    assign r_al = (D_W'(rew_reg) <<< LSH) >>> RSH;

    // New Q value before saturation.
    assign sum_q = S_W'(cur_reg) + S_W'($signed(prod_a_reg[A_W-1:COEF_FRAC]));

    // Sequencer and datapath.
    always_comb begin
        st_next       = st_reg;
        cnt_next      = cnt_reg;
        rd_vld_next   = 1'b0;
        rd_idx_next   = rd_idx_reg;
        rd_hit_next   = rd_hit_reg;
        valid_next    = valid_reg;
        learn_next    = learn_reg;
        disc_next     = disc_reg;
        kind_next     = kind_reg;
        cs_next       = cs_reg;
        row_next      = row_reg;
        act_next      = act_reg;
        rew_next      = rew_reg;
        explore_next  = explore_reg;
        ra_next       = ra_reg;
        best_val_next = best_val_reg;
        best_idx_next = best_idx_reg;
        ra_val_next   = ra_val_reg;
        cur_next      = cur_reg;
        prod_g_next   = prod_g_reg;
        diff_next     = diff_reg;
        prod_a_next   = prod_a_reg;
        res_act_next  = res_act_reg;
        res_q_next    = res_q_reg;
        m_vld_next    = m_vld_reg;
        m_data_next   = m_data_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = ADDR_W'(cs_reg) * ADDR_W'(ACTION_COUNT) + ADDR_W'(act_reg);
        ram_wr_data   = res_q_next;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = ADDR_W'(row_reg) * ADDR_W'(ACTION_COUNT)
                      + ADDR_W'(cnt_reg[ACT_W-1:0]);

        // Configuration register writes.
        if (cfg_valid) begin
            if (cfg_index == CFG_LEARN_RATE) begin
                learn_next = cfg_data[COEF_W-1:0];
            end else if (cfg_index == CFG_DISCOUNT) begin
                disc_next = cfg_data[COEF_W-1:0];
            end
        end

        // Result delivered downstream.
        if (m_vld_reg && m_tready) begin
            m_vld_next = 1'b0;
        end

        case (st_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    kind_next     = s_tuser;
                    cs_next       = s_tdata[STATE_W-1:0];
                    act_next      = s_tdata[OFF_ACT +: ACT_W];
                    rew_next      = $signed(s_tdata[OFF_REW +: REWARD_W]);
                    ra_next       = s_tdata[OFF_RA +: ACT_W];
                    explore_next  = {1'b0, s_tdata[OFF_DRAW +: DRAW_W]}
                                  < s_tdata[OFF_EPS +: EPS_W];
                    cnt_next      = '0;
                    best_val_next = '0;
                    best_idx_next = '0;
                    if (s_tuser == KIND_SELECT) begin
                        row_next = s_tdata[STATE_W-1:0];
                        st_next  = ST_SCAN;
                    end else if (s_tlast) begin
                        st_next = ST_RDCUR;
                    end else begin
                        row_next = s_tdata[OFF_NS +: STATE_W];
                        st_next  = ST_SCAN;
                    end
                end
            end

            // Read the row one entry a cycle and keep the running maximum.
            ST_SCAN: begin
                if (cnt_reg < CNT_W'(ACTION_COUNT)) begin
                    ram_rd_en   = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = cnt_reg[ACT_W-1:0];
                    rd_hit_next = valid_reg[ram_rd_addr];
                    cnt_next    = cnt_reg + CNT_W'(1);
                end
                if (rd_vld_reg) begin
                    if (rd_idx_reg == '0 || rd_q > best_val_reg) begin
                        best_val_next = rd_q;
                        best_idx_next = rd_idx_reg;
                    end
                    if (rd_idx_reg == ra_reg) begin
                        ra_val_next = rd_q;
                    end
                    if (rd_idx_reg == ACT_W'(ACTION_COUNT - 1)) begin
                        st_next = (kind_reg == KIND_SELECT) ? ST_SEL : ST_RDCUR;
                    end
                end
            end

            // Exploring takes the random action, otherwise the greedy one.
            ST_SEL: begin
                res_act_next = explore_reg ? ra_reg : best_idx_reg;
                res_q_next   = explore_reg ? ra_val_reg : best_val_reg;
                st_next      = ST_OUT;
            end

            // Fetch the entry being updated.
            ST_RDCUR: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = ram_wr_addr;
                rd_vld_next = 1'b1;
                rd_hit_next = valid_reg[ram_wr_addr];
                st_next     = ST_MUL1;
            end

            // Discounted next-state value.
            ST_MUL1: begin
                cur_next    = rd_q;
                prod_g_next = G_W'(best_val_reg) * $signed({1'b0, gamma_c});
                st_next     = ST_ADD1;
            end

            // Temporal difference error.
            ST_ADD1: begin
                diff_next = r_al + D_W'($signed(prod_g_reg[G_W-1:COEF_FRAC]))
                          - D_W'(cur_reg);
                st_next   = ST_MUL2;
            end

            // Scale by the learning rate.
            ST_MUL2: begin
                prod_a_next = A_W'(diff_reg) * $signed({1'b0, alpha_c});
                st_next     = ST_ADD2;
            end

            // Saturate, write back and set the entry's valid bit.
            ST_ADD2: begin
                if (sum_q > Q_MAX) begin
                    res_q_next = Q_MAX[Q_WIDTH-1:0];
                end else if (sum_q < Q_MIN) begin
                    res_q_next = Q_MIN[Q_WIDTH-1:0];
                end else begin
                    res_q_next = sum_q[Q_WIDTH-1:0];
                end
                res_act_next           = act_reg;
                ram_wr_en              = 1'b1;
                ram_wr_data            = res_q_next;
                valid_next[ram_wr_addr] = 1'b1;
                st_next                = ST_OUT;
            end

            // Hand the result to the output register once it is free.
            ST_OUT: begin
                if (!m_vld_reg || m_tready) begin
                    m_vld_next  = 1'b1;
                    m_data_next = M_TDATA_W'({res_q_reg, res_act_reg});
                    st_next     = ST_IDLE;
                end
            end

            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= ST_IDLE;
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
            valid_reg  <= '0;
            learn_reg  <= LEARN_RATE_RST;
            disc_reg   <= DISCOUNT_RST;
            m_vld_reg  <= 1'b0;
        end else begin
            st_reg     <= st_next;
            cnt_reg    <= cnt_next;
            rd_vld_reg <= rd_vld_next;
            valid_reg  <= valid_next;
            learn_reg  <= learn_next;
            disc_reg   <= disc_next;
            m_vld_reg  <= m_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        rd_idx_reg   <= rd_idx_next;
        rd_hit_reg   <= rd_hit_next;
        kind_reg     <= kind_next;
        cs_reg       <= cs_next;
        row_reg      <= row_next;
        act_reg      <= act_next;
        rew_reg      <= rew_next;
        explore_reg  <= explore_next;
        ra_reg       <= ra_next;
        best_val_reg <= best_val_next;
        best_idx_reg <= best_idx_next;
        ra_val_reg   <= ra_val_next;
        cur_reg      <= cur_next;
        prod_g_reg   <= prod_g_next;
        diff_reg     <= diff_next;
        prod_a_reg   <= prod_a_next;
        res_act_reg  <= res_act_next;
        res_q_reg    <= res_q_next;
        m_data_reg   <= m_data_next;
    end

endmodule

`default_nettype wire

// ===== design/qtle_checker.sv =====
// ============================================================================
// qtle_checker: port-level checks for the Q table learning engine
// Tracks outstanding requests and checks the result stream against them.
// ============================================================================
`default_nettype none

module qtle_checker
    import qtle_pkg::*;
(
    input wire                   aclk,
    input wire                   aresetn,
    input wire                   s_tvalid,
    input wire                   s_tready,
    input wire                   m_tvalid,
    input wire                   m_tready,
    input wire [M_TDATA_W-1:0]   m_tdata
);

    logic [1:0] pend_reg, pend_next;

    // Requests accepted whose results have not been taken yet.
    always_comb begin
        pend_next = pend_reg + 2'((s_tvalid && s_tready) ? 1 : 0)
                  - 2'((m_tvalid && m_tready) ? 1 : 0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // At most one result waiting and one request in progress.
    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != 2'd3)
        else $error("too many outstanding requests");

    // No result without a request behind it.
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != 2'd0)
        else $error("result without a request");

    // Requests are processed one at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in progress");

endmodule

bind q_table_learning_engine qtle_checker u_qtle_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/q_table_learning_engine_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// q_table_learning_engine_test: self-checking bench for the Q learning engine
// A shadow Q table and coefficient copy predict every select and update
// request; results are checked field by field, with both streams stalling in most tests.
// ============================================================================

module q_table_learning_engine_test
    import qtle_pkg::*;
;

    localparam int TIMEOUT_NS = 1_000_000;

    // One request as the block sees it, and one result.
    typedef struct {
        logic                       kind;
        logic [STATE_W-1:0]         cur_state;
        logic [ACT_W-1:0]           act;
        logic signed [REWARD_W-1:0] reward;
        logic [STATE_W-1:0]         nxt_state;
        logic                       terminal;
        logic [EPS_W-1:0]           epsilon;
        logic [DRAW_W-1:0]          draw;
        logic [ACT_W-1:0]           rand_act;
    } qreq_t;

    typedef struct {
        logic [ACT_W-1:0]          action;
        logic signed [Q_WIDTH-1:0] q;
    } qres_t;

    // Clock and reset.
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #1 aclk = ~aclk;

    // Block inputs, all known from time zero.
    logic                  s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  s_tready;
    logic                  m_tvalid;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_ready;

    q_table_learning_engine dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the table and the coefficients.
    logic signed [Q_WIDTH-1:0] q_shadow [DEPTH];
    logic [COEF_W-1:0]         alpha_shadow = LEARN_RATE_RST;
    logic [COEF_W-1:0]         gamma_shadow = DISCOUNT_RST;

    qres_t pending_action_q [$];
    int    mismatches  = 0;
    bit    src_idle_en = 1'b1;
    bit    snk_idle_en = 1'b1;
    int    sink_hold   = 0;

    // Greedy action of a row in the shadow table, ties to the lowest index.
    function automatic int unsigned row_best(input int unsigned st);
        int unsigned best;
        best = 0;
        for (int a = 1; a < ACTION_COUNT; a++)
            if (q_shadow[st * ACTION_COUNT + a] > q_shadow[st * ACTION_COUNT + best])
                best = a;
        return best;
    endfunction

    // Floor of v times a coefficient, coefficients above one act as one.
    function automatic longint coef_scale(input longint v, input logic [COEF_W-1:0] c);
        longint cc;
        cc = (c > COEF_ONE) ? longint'(COEF_ONE) : longint'(c);
        return (v * cc) >>> COEF_FRAC;
    endfunction

    // Works out the result of one request and applies it to the shadow table.
    function automatic qres_t predict_action_q(input qreq_t r);
        qres_t  res;
        longint next_best, r_al, target, cur, sum;
        longint qmax, qmin;
        int     slot;
        qmax = (longint'(1) <<< (Q_WIDTH - 1)) - 1;
        qmin = -qmax - 1;
        if (r.kind == KIND_SELECT) begin
            if (r.draw < r.epsilon)
                res.action = r.rand_act;
            else
                res.action = ACT_W'(row_best(r.cur_state));
            res.q = q_shadow[int'(r.cur_state) * ACTION_COUNT + res.action];
        end else begin
            next_best = 0;
            if (!r.terminal)
                next_best = q_shadow[int'(r.nxt_state) * ACTION_COUNT
                                     + row_best(r.nxt_state)];
            if (FRAC_BITS >= REWARD_FRAC)
                r_al = longint'(r.reward) <<< (FRAC_BITS - REWARD_FRAC);
            else
                r_al = longint'(r.reward) >>> (REWARD_FRAC - FRAC_BITS);
            target = r_al + coef_scale(next_best, gamma_shadow);
            slot = int'(r.cur_state) * ACTION_COUNT + r.act;
            cur = q_shadow[slot];
            sum = cur + coef_scale(target - cur, alpha_shadow);
            if (sum > qmax) sum = qmax;
            if (sum < qmin) sum = qmin;
            q_shadow[slot] = Q_WIDTH'(sum);
            res.q = Q_WIDTH'(sum);
            res.action = r.act;
        end
        return res;
    endfunction

    function automatic qreq_t make_req(input logic kind, input int st, input int ac,
                                       input int rew, input int nst, input logic term,
                                       input int eps, input int draw, input int ra);
        qreq_t r;
        r.kind       = kind;
        r.cur_state  = STATE_W'(st);
        r.act        = ACT_W'(ac);
        r.reward     = REWARD_W'(rew);
        r.nxt_state  = STATE_W'(nst);
        r.terminal   = term;
        r.epsilon    = EPS_W'(eps);
        r.draw       = DRAW_W'(draw);
        r.rand_act   = ACT_W'(ra);
        return r;
    endfunction

    function automatic qreq_t random_request();
        qreq_t r;
        r.kind       = 1'($urandom);
        r.cur_state  = STATE_W'($urandom);
        r.act        = ACT_W'($urandom);
        r.reward     = REWARD_W'($urandom);
        r.nxt_state  = STATE_W'($urandom);
        r.terminal   = 1'($urandom);
        r.epsilon    = EPS_W'($urandom);
        r.draw       = DRAW_W'($urandom);
        r.rand_act   = ACT_W'($urandom);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint expv, input longint gotv);
        mismatches++;
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, expv, gotv);
    endtask

    // Sends one request, with an occasional random gap before it, and records its result.
    task automatic send_request(input qreq_t r);
        int gap;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tlast  <= r.terminal;
        s_tdata  <= S_TDATA_W'({r.rand_act, r.draw, r.epsilon, r.nxt_state,
                                r.reward, r.act, r.cur_state});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_action_q.insert(pending_action_q.size(), predict_action_q(r));
    endtask

    // Lets every outstanding result arrive and the sequencer settle.
    task automatic wait_results_idle();
        s_tvalid <= 1'b0;
        while (pending_action_q.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_LEARN_RATE)
            alpha_shadow = val[COEF_W-1:0];
        else if (idx == CFG_DISCOUNT)
            gamma_shadow = val[COEF_W-1:0];
        @(posedge aclk);
    endtask

    // Episodes: select then update along a walk through the states, with
    // occasional stray requests mixed in.
    task automatic run_episodes(input int count);
        int    sent, len, st, v;
        qreq_t r;
        sent = 0;
        while (sent < count) begin
            st  = $urandom_range(0, STATE_COUNT - 1);
            len = $urandom_range(2, 10);
            for (int step = 0; step < len; step++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_request(random_request());
                    sent++;
                end
                r = random_request();
                r.kind = KIND_SELECT;
                r.cur_state = STATE_W'(st);
                case ($urandom_range(0, 3))
                    0: r.epsilon = '0;
                    1: r.epsilon = COEF_ONE;
                    2: r.epsilon = EPS_W'($urandom_range(0, 32768));
                    default: ;
                endcase
                send_request(r);
                r = random_request();
                r.kind = KIND_UPDATE;
                r.cur_state = STATE_W'(st);
                if ($urandom_range(0, 1) == 0)
                    r.act = ACT_W'(row_best(st));
                if ($urandom_range(0, 15) != 0) begin
                    v = int'($urandom_range(0, 131072)) - 65536;
                    r.reward = v[REWARD_W-1:0];
                end
                r.terminal = (step == len - 1) || ($urandom_range(0, 7) == 0);
                send_request(r);
                sent += 2;
                st = r.nxt_state;
            end
        end
    endtask

    // Fresh table and reset coefficients.
    task automatic test_reset_defaults();
        send_request(make_req(KIND_SELECT, 0, 0, 0, 0, 1'b0, 0, 0, 0));
        send_request(make_req(KIND_SELECT, 15, 0, 0, 0, 1'b0, 65536, 65535, 3));
        send_request(make_req(KIND_UPDATE, 3, 2, 65536, 0, 1'b1, 0, 0, 0));
        send_request(make_req(KIND_UPDATE, 5, 1, 0, 3, 1'b0, 0, 0, 0));
        send_request(make_req(KIND_SELECT, 3, 0, 0, 0, 1'b0, 0, 0, 0));
    endtask

    // Exploration threshold, ties in the argmax and negative entries.
    task automatic test_select_rules();
        send_request(make_req(KIND_UPDATE, 3, 0, 65536, 0, 1'b1, 0, 0, 0));
        send_request(make_req(KIND_SELECT, 3, 0, 0, 0, 1'b0, 0, 0, 0));
        send_request(make_req(KIND_SELECT, 3, 0, 0, 0, 1'b0, 100, 100, 3));
        send_request(make_req(KIND_SELECT, 3, 0, 0, 0, 1'b0, 100, 99, 3));
        send_request(make_req(KIND_SELECT, 3, 0, 0, 0, 1'b0, 'h1FFFF, 65535, 1));
        send_request(make_req(KIND_UPDATE, 7, 0, -8388608, 0, 1'b1, 0, 0, 0));
        send_request(make_req(KIND_SELECT, 7, 0, 0, 0, 1'b0, 0, 0, 0));
        wait_results_idle();
    endtask

    // Coefficients at zero, one and above one; saturation both ways; writes
    // to indexes past the register list.
    task automatic test_coefficient_extremes();
        write_register(CFG_LEARN_RATE, 32'd65536);
        write_register(CFG_DISCOUNT, 32'd65536);
        send_request(make_req(KIND_UPDATE, 8, 0, 8388607, 0, 1'b1, 0, 0, 0));
        send_request(make_req(KIND_UPDATE, 8, 1, 8388607, 8, 1'b0, 0, 0, 0));
        for (int a = 0; a < ACTION_COUNT; a++)
            send_request(make_req(KIND_UPDATE, 9, a, -8388608, 0, 1'b1, 0, 0, 0));
        send_request(make_req(KIND_UPDATE, 10, 0, -8388608, 9, 1'b0, 0, 0, 0));
        wait_results_idle();
        write_register(CFG_LEARN_RATE, 32'd0);
        write_register(CFG_DISCOUNT, 32'hFFFF_FFFF);
        send_request(make_req(KIND_UPDATE, 8, 2, 12345, 8, 1'b0, 0, 0, 0));
        wait_results_idle();
        write_register(CFG_LEARN_RATE, 32'h0001_FFFF);
        write_register(CFG_DISCOUNT, 32'd0);
        write_register(CFG_IDX_W'(2), 32'd0);
        write_register(CFG_IDX_W'(255), 32'hFFFF_FFFF);
        send_request(make_req(KIND_UPDATE, 11, 3, -65536, 8, 1'b0, 0, 0, 0));
        send_request(make_req(KIND_UPDATE, 11, 3, 0, 0, 1'b1, 0, 0, 0));
        wait_results_idle();
    endtask

    // Learning runs under a series of coefficient settings.
    task automatic test_random_learning();
        for (int k = 0; k < 6; k++) begin
            case (k)
                0: begin
                    write_register(CFG_LEARN_RATE, 32'(LEARN_RATE_RST));
                    write_register(CFG_DISCOUNT, 32'(DISCOUNT_RST));
                end
                1: begin
                    write_register(CFG_LEARN_RATE, 32'd1);
                    write_register(CFG_DISCOUNT, 32'd65535);
                end
                2, 3: begin
                    write_register(CFG_LEARN_RATE, 32'($urandom_range(0, 65536)));
                    write_register(CFG_DISCOUNT, 32'($urandom_range(0, 65536)));
                end
                4: begin
                    write_register(CFG_LEARN_RATE, $urandom);
                    write_register(CFG_DISCOUNT, $urandom);
                end
                default: begin
                    write_register(CFG_LEARN_RATE, 32'd65536);
                    write_register(CFG_DISCOUNT, 32'd65536);
                end
            endcase
            write_register(CFG_IDX_W'($urandom_range(2, 255)), $urandom);
            run_episodes(95);
            wait_results_idle();
        end
    endtask

    // Unstructured requests with every field drawn at random.
    task automatic test_random_fields();
        write_register(CFG_LEARN_RATE, 32'($urandom_range(0, 65536)));
        write_register(CFG_DISCOUNT, $urandom);
        for (int i = 0; i < 100; i++)
            send_request(random_request());
        wait_results_idle();
    endtask

    // Back-to-back traffic with neither side idling.
    task automatic test_quiet_tail();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        write_register(CFG_LEARN_RATE, 32'($urandom_range(0, 65536)));
        write_register(CFG_DISCOUNT, 32'($urandom_range(0, 65536)));
        run_episodes(100);
    endtask

    // Result stream pacing: random stalls between ready stretches.
    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
        end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
            m_tready  <= 1'b0;
            sink_hold <= $urandom_range(0, 16);
        end else begin
            m_tready  <= 1'b1;
            sink_hold <= snk_idle_en ? $urandom_range(0, 30) : 0;
        end
    end

    // Compares each accepted result with the oldest prediction.
    always @(posedge aclk) begin : check_results
        qres_t head;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (pending_action_q.size() == 0) begin
                report_mismatch("unexpected result, q_value", 0,
                                longint'($signed(m_tdata[ACT_W +: Q_WIDTH])));
            end else begin
                head = pending_action_q.pop_front();
                if (m_tdata[ACT_W-1:0] !== head.action)
                    report_mismatch("chosen_action", longint'(head.action),
                                    longint'(m_tdata[ACT_W-1:0]));
                if (m_tdata[ACT_W +: Q_WIDTH] !== head.q)
                    report_mismatch("q_value", longint'(head.q),
                                    longint'($signed(m_tdata[ACT_W +: Q_WIDTH])));
            end
        end
    end

    initial begin
        foreach (q_shadow[i]) q_shadow[i] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_select_rules();
        test_coefficient_extremes();
        test_random_learning();
        test_random_fields();
        test_quiet_tail();
        wait_results_idle();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule
